// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the longest unique run block.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: check failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lurl_pkg.sv =====
// Types and fixed constants of the longest unique run block.
// No dependencies; used by the channel interfaces and the top level.
package lurl_pkg;

   localparam int SYMBOL_W        = 8;
   localparam int MAX_SYMBOL_BITS = 16;
   localparam int LENGTH_W        = 16;
   localparam int EPOCH_BITS      = 8;

   localparam logic [LENGTH_W-1:0]   LENGTH_MAX = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_STALE = '0;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_symbol;
   } req_payload_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] longest_length;
      logic                too_long;
   } rsp_payload_type;

endpackage

// ===== rtl/lurl_if.sv =====
// Valid/ready channel interfaces for the longest unique run block.
// Depends on lurl_pkg for the payload types.
interface lurl_req_if;
   logic                      valid;
   logic                      ready;
   lurl_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lurl_rsp_if;
   logic                      valid;
   logic                      ready;
   lurl_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/longest_unique_run_length.sv =====
// Longest run without a repeated symbol, one string symbol per transfer.
// Depends on lurl_pkg, lurl_if.sv and assert_macros.svh.
//
// req_chan carries one symbol per transfer; last_symbol marks the end of a
// string. On that final symbol one transfer leaves on rsp_chan with the
// length of the longest run holding no repeated symbol, and too_long set if
// the string reached the top of the position counter. Other symbols give no result.
// A result is registered in two steps: the table read into stage 1 when its
// final symbol is taken, then the window update and the result register.
// One symbol per cycle is taken, set by the single read and write port of
// the last-seen table, unless a clearing pass or a final symbol held in
// stage 1 keeps req_chan.ready low. Each table entry carries a string tag,
// so the table needs no clearing between strings. After reset, and again
// after every 2^EPOCH_BITS-1 strings when the tag wraps, a clearing pass
// writes all 2^SYMBOL_BITS entries (256 at the default) with req_chan.ready low.
// While rsp_chan is stalled with a result waiting, further symbols of the
// next string are still taken; only a second final symbol waits until the
// result register is free.
`include "assert_macros.svh"

module longest_unique_run_length #(
   parameter int POS_BITS    = 16,
   parameter int SYMBOL_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   lurl_req_if.sink    req_chan,
   lurl_rsp_if.source  rsp_chan
);
   import lurl_pkg::*;

   localparam int DEPTH = 1 << SYMBOL_BITS;
   localparam int CUR_W = (POS_BITS > LENGTH_W) ? POS_BITS + 1 : LENGTH_W + 1;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [POS_BITS-1:0]   position;
   } entry_type;

   // last-seen table
   entry_type mem [DEPTH];

   logic [MAX_SYMBOL_BITS-1:0] symbol_wide;
   logic [SYMBOL_BITS-1:0]     req_index;
   logic                       req_accept;

   // stage 1: item waiting for its table data
   logic                   s1_valid_ff;
   logic [SYMBOL_BITS-1:0] s1_index_ff;
   logic                   s1_last_ff;
   entry_type              rd_raw_ff;
   logic                   fwd_hit_ff;
   entry_type              fwd_entry_ff;

   // per-string state
   logic [EPOCH_BITS-1:0]  epoch_ff;
   logic [POS_BITS-1:0]    pos_count_ff, pos_count_in;
   logic [POS_BITS-1:0]    win_start_ff, win_start_in;
   logic [LENGTH_W-1:0]    best_ff, best_in;
   logic                   ovf_ff, ovf_in;

   logic                   clearing_ff;
   logic [SYMBOL_BITS-1:0] clr_index_ff;

   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff;

   logic                   advance;
   logic                   wrap_hold;
   entry_type              entry_cur;
   logic                   hit;
   logic [POS_BITS-1:0]    diff;
   logic [CUR_W-1:0]       cur_len;
   logic [LENGTH_W-1:0]    len_sat;
   logic                   pos_sat;
   logic                   wr_en;
   logic [SYMBOL_BITS-1:0] wr_addr;
   entry_type              wr_entry;

   assign symbol_wide = MAX_SYMBOL_BITS'(req_chan.data.symbol);
   assign req_index   = symbol_wide[SYMBOL_BITS-1:0];

   // a final symbol moves on only if the result register can take it
   assign advance   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_chan.ready);
   // final symbol of the last tag value: hold input for the clearing pass
   assign wrap_hold = s1_valid_ff && s1_last_ff && (epoch_ff == EPOCH_LAST);

   assign req_chan.ready = !clearing_ff && !wrap_hold && (!s1_valid_ff || advance);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      entry_cur = fwd_hit_ff ? fwd_entry_ff : rd_raw_ff;
      hit = (entry_cur.epoch == epoch_ff) && (entry_cur.position >= win_start_ff);

      if (hit) begin
         win_start_in = (entry_cur.position == POS_MAX) ? POS_MAX
                                                        : entry_cur.position + 1'b1;
      end else begin
         win_start_in = win_start_ff;
      end

      diff = pos_count_ff - win_start_in;
      if (pos_count_ff >= win_start_in) begin
         cur_len = CUR_W'(diff) + CUR_W'(1);
      end else begin
         cur_len = CUR_W'(1);
      end
      len_sat = (cur_len > CUR_W'(LENGTH_MAX)) ? LENGTH_MAX : cur_len[LENGTH_W-1:0];
      best_in = (len_sat > best_ff) ? len_sat : best_ff;

      pos_sat      = (pos_count_ff == POS_MAX);
      ovf_in       = ovf_ff || pos_sat;
      pos_count_in = pos_sat ? pos_count_ff : pos_count_ff + 1'b1;

      wr_en   = clearing_ff || advance;
      wr_addr = clearing_ff ? clr_index_ff : s1_index_ff;
      if (clearing_ff) begin
         wr_entry = '{epoch: EPOCH_STALE, position: '0};
      end else begin
         wr_entry = '{epoch: epoch_ff, position: pos_count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // read on transfer; a write to the same entry at that edge is forwarded
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_raw_ff    <= mem[req_index];
         fwd_hit_ff   <= advance && (s1_index_ff == req_index);
         fwd_entry_ff <= wr_entry;
         s1_index_ff  <= req_index;
         s1_last_ff   <= req_chan.data.last_symbol;
      end
      if (advance && s1_last_ff) begin
         rsp_data_ff <= '{longest_length: best_in, too_long: ovf_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_index_ff <= '0;
         epoch_ff     <= EPOCH_FIRST;
         pos_count_ff <= '0;
         win_start_ff <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (clearing_ff) begin
            clr_index_ff <= clr_index_ff + 1'b1;
            if (clr_index_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end

         if (advance) begin
            if (s1_last_ff) begin
               pos_count_ff <= '0;
               win_start_ff <= '0;
               best_ff      <= '0;
               ovf_ff       <= 1'b0;
               if (epoch_ff == EPOCH_LAST) begin
                  epoch_ff     <= EPOCH_FIRST;
                  clearing_ff  <= 1'b1;
                  clr_index_ff <= '0;
               end else begin
                  epoch_ff <= epoch_ff + 1'b1;
               end
            end else begin
               pos_count_ff <= pos_count_in;
               win_start_ff <= win_start_in;
               best_ff      <= best_in;
               ovf_ff       <= ovf_in;
            end
         end
      end
   end

   `ASSERT_ALWAYS(a_no_transfer_clearing, clock, reset, !(clearing_ff && req_accept))
   `ASSERT_ALWAYS(a_window_in_range, clock, reset, win_start_ff <= pos_count_ff)
   `ASSERT_IMPLIES(a_best_nonzero, clock, reset, pos_count_ff != '0, best_ff != '0)
   `ASSERT_NEXT(a_final_gives_result, clock, reset, advance && s1_last_ff, rsp_valid_ff)
   `ASSERT_ALWAYS(a_epoch_live, clock, reset, epoch_ff != EPOCH_STALE)

endmodule
